### src/hpp_pkg.sv
// Shared types and constants of the Hanning power bit packer.
package hpp_pkg;

  localparam int WORD_W      = 64;
  localparam int BIN_W       = 16;
  localparam int SUM_W       = 19;
  localparam int PROD_W      = 34;
  localparam int MAG_W       = 28;
  localparam int SQ_W        = 2 * MAG_W;
  localparam int FRAC_SHIFT  = 48;
  localparam int PWR_W       = SQ_W + 1 - FRAC_SHIFT;
  localparam int RAW_SHIFT   = 16;
  localparam int SCALE_W     = 15;
  localparam logic [SCALE_W-1:0] HANN_SCALE = 15'd26755;
  localparam int QUEUE_AW    = 2;
  localparam int QUEUE_DEPTH = 1 << QUEUE_AW;

  typedef enum logic [0:0] {
    OP_RESTART = 1'b0,
    OP_BIN     = 1'b1
  } op_kind_t;

  typedef enum logic [2:0] {
    PRIME_IDLE  = 3'b001,
    PRIME_GUARD = 3'b010,
    PRIME_FULL  = 3'b100
  } prime_state_t;

  typedef struct packed {
    op_kind_t           kind;
    logic               last;
    logic               hann;
    logic [SUM_W-1:0]   opr_re;
    logic [SUM_W-1:0]   opr_im;
  } back_op_t;

endpackage

### src/hpp_front.sv
// Front end: accepts bins, tracks the window and spectrum state, issues back-end ops.
module hpp_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic                  cfg_wr_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [15:0]           in_bin_real,
  input  logic [15:0]           in_bin_imag,
  input  logic                  in_spectrum_first,
  input  logic                  in_spectrum_last,
  output logic                  q_push,
  output hpp_pkg::back_op_t     q_push_data,
  input  logic                  q_full
);

  hpp_pkg::prime_state_t            prime_r, prime_nxt;
  logic                             hann_r;
  logic [hpp_pkg::BIN_W-1:0]        mid_re_r, mid_im_r, old_re_r, old_im_r;
  logic [hpp_pkg::BIN_W-1:0]        mid_re_nxt, mid_im_nxt, old_re_nxt, old_im_nxt;
  logic [hpp_pkg::SUM_W-1:0]        sum_re, sum_im;
  logic                             accept;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  always_comb begin
    sum_re = {{2{mid_re_r[hpp_pkg::BIN_W-1]}}, mid_re_r, 1'b0}
           + {{3{old_re_r[hpp_pkg::BIN_W-1]}}, old_re_r}
           + {{3{in_bin_real[hpp_pkg::BIN_W-1]}}, in_bin_real};
    sum_im = {{2{mid_im_r[hpp_pkg::BIN_W-1]}}, mid_im_r, 1'b0}
           + {{3{old_im_r[hpp_pkg::BIN_W-1]}}, old_im_r}
           + {{3{in_bin_imag[hpp_pkg::BIN_W-1]}}, in_bin_imag};
  end

  always_comb begin
    prime_nxt  = prime_r;
    mid_re_nxt = mid_re_r;
    mid_im_nxt = mid_im_r;
    old_re_nxt = old_re_r;
    old_im_nxt = old_im_r;
    q_push     = 1'b0;
    q_push_data.kind   = hpp_pkg::OP_BIN;
    q_push_data.last   = in_spectrum_last;
    q_push_data.hann   = hann_r;
    q_push_data.opr_re = hann_r ? sum_re : {{3{mid_re_r[hpp_pkg::BIN_W-1]}}, mid_re_r};
    q_push_data.opr_im = hann_r ? sum_im : {{3{mid_im_r[hpp_pkg::BIN_W-1]}}, mid_im_r};
    if (accept) begin
      if (in_spectrum_first) begin
        mid_re_nxt = in_bin_real;
        mid_im_nxt = in_bin_imag;
        old_re_nxt = '0;
        old_im_nxt = '0;
        prime_nxt  = in_spectrum_last ? hpp_pkg::PRIME_IDLE : hpp_pkg::PRIME_GUARD;
        q_push     = 1'b1;
        q_push_data.kind = hpp_pkg::OP_RESTART;
      end else begin
        case (prime_r)
          hpp_pkg::PRIME_IDLE: begin
            prime_nxt = hpp_pkg::PRIME_IDLE;
          end
          hpp_pkg::PRIME_GUARD: begin
            old_re_nxt = mid_re_r;
            old_im_nxt = mid_im_r;
            mid_re_nxt = in_bin_real;
            mid_im_nxt = in_bin_imag;
            prime_nxt  = in_spectrum_last ? hpp_pkg::PRIME_IDLE : hpp_pkg::PRIME_FULL;
          end
          hpp_pkg::PRIME_FULL: begin
            old_re_nxt = mid_re_r;
            old_im_nxt = mid_im_r;
            mid_re_nxt = in_bin_real;
            mid_im_nxt = in_bin_imag;
            q_push     = 1'b1;
            if (in_spectrum_last) begin
              prime_nxt = hpp_pkg::PRIME_IDLE;
            end
          end
          default: begin
            prime_nxt = hpp_pkg::PRIME_IDLE;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prime_r <= hpp_pkg::PRIME_IDLE;
      hann_r  <= 1'b1;
    end else begin
      prime_r <= prime_nxt;
      if (cfg_wr_en) begin
        hann_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    mid_re_r <= mid_re_nxt;
    mid_im_r <= mid_im_nxt;
    old_re_r <= old_re_nxt;
    old_im_r <= old_im_nxt;
  end

endmodule

### src/hpp_queue.sv
// Op queue between the front end and the power back end.
module hpp_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  hpp_pkg::back_op_t     push_data,
  output logic                  full,
  input  logic                  pop,
  output hpp_pkg::back_op_t     head_data,
  output logic                  empty
);

  hpp_pkg::back_op_t                entry_r [hpp_pkg::QUEUE_DEPTH];
  logic [hpp_pkg::QUEUE_AW-1:0]     wr_ptr_r, rd_ptr_r;
  logic [hpp_pkg::QUEUE_AW:0]       count_r, count_nxt;

  assign full      = count_r == (hpp_pkg::QUEUE_AW+1)'(hpp_pkg::QUEUE_DEPTH);
  assign empty     = count_r == '0;
  assign head_data = entry_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

### src/hpp_back.sv
// Back end: scale, square, saturate and pack powers into output words.
module hpp_back #(
  parameter int BINS_PER_WORD = 32,
  parameter int BITS_PER_BIN  = 2
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       q_empty,
  input  hpp_pkg::back_op_t          q_head,
  output logic                       q_pop,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [hpp_pkg::WORD_W-1:0] out_packed_word,
  output logic                       out_word_last
);

  localparam int POS_W = (BINS_PER_WORD > 1) ? $clog2(BINS_PER_WORD) : 1;
  localparam int SH_W  = $clog2(BINS_PER_WORD * BITS_PER_BIN + 1);
  localparam logic [BITS_PER_BIN-1:0] MAXV = {BITS_PER_BIN{1'b1}};

  logic                              adv;

  logic                              s1_valid_r;
  hpp_pkg::op_kind_t                 s1_kind_r;
  logic                              s1_last_r;
  logic [hpp_pkg::PROD_W-1:0]        s1_re_r, s1_im_r;
  logic [hpp_pkg::PROD_W-1:0]        p1_re, p1_im;

  logic                              s2_valid_r;
  hpp_pkg::op_kind_t                 s2_kind_r;
  logic                              s2_last_r;
  logic                              s2_sat_r;
  logic [hpp_pkg::SQ_W-1:0]          s2_sq_re_r, s2_sq_im_r;
  logic [hpp_pkg::PROD_W-1:0]        mag_re, mag_im;

  logic                              s3_valid_r;
  hpp_pkg::op_kind_t                 s3_kind_r;
  logic                              s3_last_r;
  logic [BITS_PER_BIN-1:0]           s3_pwr_r;
  logic [hpp_pkg::SQ_W:0]            sq_total;
  logic [hpp_pkg::PWR_W-1:0]         pwr_full;
  logic [BITS_PER_BIN-1:0]           pwr;

  logic [POS_W-1:0]                  pos_r, pos_nxt;
  logic [hpp_pkg::WORD_W-1:0]        accum_r, accum_nxt, word_fill;
  logic [POS_W:0]                    pos_inc;
  logic [SH_W-1:0]                   shift;
  logic                              emit;
  logic                              out_valid_r, out_valid_nxt;
  logic [hpp_pkg::WORD_W-1:0]        out_word_r;
  logic                              out_last_r;

  assign adv             = !out_valid_r || !out_stall;
  assign q_pop           = adv && !q_empty;
  assign out_valid       = out_valid_r;
  assign out_packed_word = out_word_r;
  assign out_word_last   = out_last_r;

  always_comb begin
    if (q_head.hann) begin
      p1_re = {{(hpp_pkg::PROD_W-hpp_pkg::SUM_W){q_head.opr_re[hpp_pkg::SUM_W-1]}},
               q_head.opr_re}
            * {{(hpp_pkg::PROD_W-hpp_pkg::SCALE_W){1'b0}}, hpp_pkg::HANN_SCALE};
      p1_im = {{(hpp_pkg::PROD_W-hpp_pkg::SUM_W){q_head.opr_im[hpp_pkg::SUM_W-1]}},
               q_head.opr_im}
            * {{(hpp_pkg::PROD_W-hpp_pkg::SCALE_W){1'b0}}, hpp_pkg::HANN_SCALE};
    end else begin
      p1_re = {{(hpp_pkg::PROD_W-hpp_pkg::BIN_W-hpp_pkg::RAW_SHIFT)
                {q_head.opr_re[hpp_pkg::BIN_W-1]}},
               q_head.opr_re[hpp_pkg::BIN_W-1:0], {hpp_pkg::RAW_SHIFT{1'b0}}};
      p1_im = {{(hpp_pkg::PROD_W-hpp_pkg::BIN_W-hpp_pkg::RAW_SHIFT)
                {q_head.opr_im[hpp_pkg::BIN_W-1]}},
               q_head.opr_im[hpp_pkg::BIN_W-1:0], {hpp_pkg::RAW_SHIFT{1'b0}}};
    end
  end

  always_comb begin
    mag_re = s1_re_r[hpp_pkg::PROD_W-1] ? (~s1_re_r + 1'b1) : s1_re_r;
    mag_im = s1_im_r[hpp_pkg::PROD_W-1] ? (~s1_im_r + 1'b1) : s1_im_r;
  end

  always_comb begin
    sq_total = {1'b0, s2_sq_re_r} + {1'b0, s2_sq_im_r};
    pwr_full = sq_total[hpp_pkg::SQ_W:hpp_pkg::FRAC_SHIFT];
    if (s2_sat_r || (pwr_full > hpp_pkg::PWR_W'(MAXV))) begin
      pwr = MAXV;
    end else begin
      pwr = pwr_full[BITS_PER_BIN-1:0];
    end
  end

  always_comb begin
    pos_inc   = {1'b0, pos_r} + 1'b1;
    shift     = SH_W'(pos_r) * SH_W'(BITS_PER_BIN);
    word_fill = accum_r
              | ({{(hpp_pkg::WORD_W-BITS_PER_BIN){1'b0}}, s3_pwr_r} << shift);
    emit      = 1'b0;
    pos_nxt   = pos_r;
    accum_nxt = accum_r;
    if (adv && s3_valid_r) begin
      case (s3_kind_r)
        hpp_pkg::OP_RESTART: begin
          pos_nxt   = '0;
          accum_nxt = '0;
        end
        hpp_pkg::OP_BIN: begin
          if (s3_last_r || (pos_inc == (POS_W+1)'(BINS_PER_WORD))) begin
            emit      = 1'b1;
            pos_nxt   = '0;
            accum_nxt = '0;
          end else begin
            pos_nxt   = pos_inc[POS_W-1:0];
            accum_nxt = word_fill;
          end
        end
        default: begin
          pos_nxt = pos_r;
        end
      endcase
    end
    out_valid_nxt = out_valid_r && out_stall;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      pos_r       <= '0;
      accum_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (adv) begin
        s1_valid_r <= q_pop;
        s2_valid_r <= s1_valid_r;
        s3_valid_r <= s2_valid_r;
      end
      pos_r       <= pos_nxt;
      accum_r     <= accum_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_kind_r  <= q_head.kind;
      s1_last_r  <= q_head.last;
      s1_re_r    <= p1_re;
      s1_im_r    <= p1_im;
      s2_kind_r  <= s1_kind_r;
      s2_last_r  <= s1_last_r;
      s2_sat_r   <= (|mag_re[hpp_pkg::PROD_W-1:hpp_pkg::MAG_W])
                 || (|mag_im[hpp_pkg::PROD_W-1:hpp_pkg::MAG_W]);
      s2_sq_re_r <= {{hpp_pkg::MAG_W{1'b0}}, mag_re[hpp_pkg::MAG_W-1:0]}
                  * {{hpp_pkg::MAG_W{1'b0}}, mag_re[hpp_pkg::MAG_W-1:0]};
      s2_sq_im_r <= {{hpp_pkg::MAG_W{1'b0}}, mag_im[hpp_pkg::MAG_W-1:0]}
                  * {{hpp_pkg::MAG_W{1'b0}}, mag_im[hpp_pkg::MAG_W-1:0]};
      s3_kind_r  <= s2_kind_r;
      s3_last_r  <= s2_last_r;
      s3_pwr_r   <= pwr;
    end
    if (emit) begin
      out_word_r <= word_fill;
      out_last_r <= s3_last_r;
    end
  end

endmodule

### src/hanning_power_two_bit_packer.sv
// Top level of the Hanning-windowed power bit packer.
//
//   channel  direction  handshake             payload
//   in       input      in_valid / in_stall   in_bin_real, in_bin_imag,
//                                             in_spectrum_first, in_spectrum_last
//   out      output     out_valid / out_stall out_packed_word, out_word_last
//   cfg      input      cfg_wr_en             cfg_wr_data (hanning enable)
//
// One bin is taken per cycle; in_stall rises only when the four-entry op queue is full.
// A word leaves once the bin that completes it has passed the op queue, the back end's
// three-stage scale/square/saturate pipeline and the packing output register.
// Reset is synchronous: it empties queue and pipeline and sets the hanning enable to 1.
// A stalled word freezes the whole back end; the front keeps taking bins until the queue fills.
module hanning_power_two_bit_packer #(
  parameter int BINS_PER_WORD = 32,
  parameter int BITS_PER_BIN  = 2
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_wr_en,
  input  logic                       cfg_wr_data,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [15:0]                in_bin_real,
  input  logic [15:0]                in_bin_imag,
  input  logic                       in_spectrum_first,
  input  logic                       in_spectrum_last,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [hpp_pkg::WORD_W-1:0] out_packed_word,
  output logic                       out_word_last
);

  logic               q_push, q_full, q_pop, q_empty;
  hpp_pkg::back_op_t  q_push_data, q_head;

  hpp_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_bin_real       (in_bin_real),
    .in_bin_imag       (in_bin_imag),
    .in_spectrum_first (in_spectrum_first),
    .in_spectrum_last  (in_spectrum_last),
    .q_push            (q_push),
    .q_push_data       (q_push_data),
    .q_full            (q_full)
  );

  hpp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_data),
    .full      (q_full),
    .pop       (q_pop),
    .head_data (q_head),
    .empty     (q_empty)
  );

  hpp_back #(
    .BINS_PER_WORD (BINS_PER_WORD),
    .BITS_PER_BIN  (BITS_PER_BIN)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_empty         (q_empty),
    .q_head          (q_head),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_packed_word (out_packed_word),
    .out_word_last   (out_word_last)
  );

endmodule

### src/hpp_checker.sv
// Port-level checker for the Hanning power bit packer and its bind.
module hpp_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_stall,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [hpp_pkg::WORD_W-1:0] out_packed_word,
  input logic                       out_word_last
);

  a_reset_out_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  a_reset_in_free: assert property (@(posedge clk) !rst_n |=> !in_stall)
    else $error("in_stall high after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("stalled result dropped");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_packed_word) && $stable(out_word_last))
    else $error("stalled result changed");

endmodule

bind hanning_power_two_bit_packer hpp_checker u_hpp_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_packed_word (out_packed_word),
  .out_word_last   (out_word_last)
);
